// ===== sv/rmtv_pkg.sv =====
// Shared constants and transaction types for the two-vector rotation matrix block.
`default_nettype none
package rmtv_pkg;

    localparam int C_IN_W   = 16;
    localparam int C_OUT_W  = 16;
    localparam int C_FRAC   = 14;
    localparam int C_Q_W    = C_FRAC + 2;
    localparam int C_M_W    = C_FRAC + 4;
    localparam int C_SQ_ST  = 32;
    localparam int C_DIV_ST = C_FRAC + 2;
    localparam int C_FRONT  = 5;
    localparam int C_BACK   = 3;
    localparam int C_NST    = C_FRONT + C_SQ_ST + C_DIV_ST + C_BACK;
    localparam int C_NDIV   = 10;

    typedef struct packed {
        logic signed [C_IN_W-1:0] before_x;
        logic signed [C_IN_W-1:0] before_y;
        logic signed [C_IN_W-1:0] before_z;
        logic signed [C_IN_W-1:0] after_x;
        logic signed [C_IN_W-1:0] after_y;
        logic signed [C_IN_W-1:0] after_z;
    } t_in;

    typedef struct packed {
        logic signed [C_OUT_W-1:0] m_row0_col0;
        logic signed [C_OUT_W-1:0] m_row0_col1;
        logic signed [C_OUT_W-1:0] m_row0_col2;
        logic signed [C_OUT_W-1:0] m_row1_col0;
        logic signed [C_OUT_W-1:0] m_row1_col1;
        logic signed [C_OUT_W-1:0] m_row1_col2;
        logic signed [C_OUT_W-1:0] m_row2_col0;
        logic signed [C_OUT_W-1:0] m_row2_col1;
        logic signed [C_OUT_W-1:0] m_row2_col2;
        logic                      degenerate;
    } t_out;

    typedef struct packed {
        logic [63:0]          ss;
        logic [2:0][63:0]     csq;
        logic [2:0][63:0]     cc;
        logic [2:0][31:0]     absc;
        logic [2:0]           csgn;
        logic [31:0]          absd;
        logic                 dsgn;
        logic                 degen;
    } t_mid;

    typedef struct packed {
        logic [2:0] csgn;
        logic       dsgn;
        logic       degen;
    } t_sgn;

endpackage
`default_nettype wire

// ===== sv/rmtv_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
`default_nettype none
module rmtv_sqrt
    import rmtv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_x,
    output logic      [31:0] o_root
);

    logic [63:0] r_rem  [C_SQ_ST];
    logic [63:0] r_root [C_SQ_ST];

    for (genvar g = 0; g < C_SQ_ST; g++) begin : g_st
        localparam int SH = 2 * (C_SQ_ST - 1) - 2 * g;
        logic [63:0] rem_in;
        logic [63:0] root_in;
        logic [63:0] bitv;
        logic [63:0] trial;

        if (g == 0) begin : g_first
            assign rem_in  = i_x;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        assign bitv  = 64'(1) << SH;
        assign trial = root_in + bitv;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[g]  <= rem_in - trial;
                    r_root[g] <= (root_in >> 1) + bitv;
                end else begin
                    r_rem[g]  <= rem_in;
                    r_root[g] <= root_in >> 1;
                end
            end
        end
    end

    assign o_root = r_root[C_SQ_ST-1][31:0];

endmodule
`default_nettype wire

// ===== sv/rmtv_div.sv =====
// Pipelined restoring divider giving floor(num * 2^(FRAC+1) / den) for num <= den.
`default_nettype none
module rmtv_div
    import rmtv_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [63:0]      i_num,
    input  wire logic [63:0]      i_den,
    output logic      [C_Q_W-1:0] o_quot
);

    logic [63:0]      r_rem [C_DIV_ST];
    logic [63:0]      r_den [C_DIV_ST];
    logic [C_Q_W-1:0] r_q   [C_DIV_ST];

    for (genvar g = 0; g < C_DIV_ST; g++) begin : g_st
        if (g == 0) begin : g_first
            logic ge;
            assign ge = i_num >= i_den;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= ge ? i_num - i_den : i_num;
                    r_q[g]   <= C_Q_W'(ge);
                    r_den[g] <= i_den;
                end
            end
        end else begin : g_next
            logic [64:0] r2;
            logic [64:0] diff;
            logic        ge;
            assign r2   = {r_rem[g-1], 1'b0};
            assign diff = r2 - {1'b0, r_den[g-1]};
            assign ge   = r2 >= {1'b0, r_den[g-1]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= ge ? diff[63:0] : r2[63:0];
                    r_q[g]   <= {r_q[g-1][C_Q_W-2:0], ge};
                    r_den[g] <= r_den[g-1];
                end
            end
        end
    end

    assign o_quot = r_q[C_DIV_ST-1];

endmodule
`default_nettype wire

// ===== sv/rotation_matrix_from_two_vectors.sv =====
// Rotation matrix from two vectors by Rodrigues' formula, fully pipelined.
// Throughput is one transaction per cycle while the output skid buffer is empty;
// depth is set by the 32-stage square root and the 16-stage dividers between the
// product stages and the final sums.
// Reset clears only the valid bits of the pipeline and the output skid buffer.
`default_nettype none
module rotation_matrix_from_two_vectors
    import rmtv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam logic signed [C_FRAC+2:0] C_ONE_S  = (C_FRAC + 3)'(1) << C_FRAC;
    localparam logic signed [C_M_W-1:0]  C_ONE_M  = C_M_W'(1) << C_FRAC;
    localparam logic signed [C_M_W-1:0]  C_NONE_M = -C_ONE_M;
    localparam logic signed [C_OUT_W-1:0] C_ONE_O = C_OUT_W'(1) << C_FRAC;
    localparam logic [31:0]              C_HALF   = 32'(1) << (C_FRAC - 1);

    function automatic logic [C_FRAC:0] f_rnd(input logic [C_Q_W-1:0] q);
        logic [C_Q_W:0] s;
        s = {1'b0, q} + (C_Q_W + 1)'(1);
        return s[C_FRAC+1:1];
    endfunction

    function automatic logic signed [C_FRAC+2:0] f_sgn(input logic [C_FRAC:0] m,
                                                      input logic neg);
        logic signed [C_FRAC+2:0] e;
        e = $signed({2'b00, m});
        return neg ? -e : e;
    endfunction

    function automatic logic signed [C_OUT_W-1:0] f_sat(input logic signed [C_M_W-1:0] v);
        logic signed [C_M_W-1:0] c;
        c = v;
        if (v > C_ONE_M) begin
            c = C_ONE_M;
        end else if (v < C_NONE_M) begin
            c = C_NONE_M;
        end
        return c[C_OUT_W-1:0];
    endfunction

    logic             w_en;
    logic [C_NST-1:0] r_v;
    logic             r_out_v;
    logic             r_sk_v;
    t_out             r_out_d;
    t_out             r_sk_d;
    t_out             r_tail;

    assign w_en       = !r_sk_v;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[C_NST-2:0], i_in_valid};
        end
    end

    t_in r_s1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= i_in_data;
        end
    end

    logic signed [C_IN_W-1:0] w_a [3];
    logic signed [C_IN_W-1:0] w_b [3];
    assign w_a[0] = r_s1.before_x;
    assign w_a[1] = r_s1.before_y;
    assign w_a[2] = r_s1.before_z;
    assign w_b[0] = r_s1.after_x;
    assign w_b[1] = r_s1.after_y;
    assign w_b[2] = r_s1.after_z;

    logic signed [31:0] r_s2_ab [3][3];
    logic [30:0]        r_s2_aa [3];
    logic [30:0]        r_s2_bb [3];
    logic signed [31:0] w_aa  [3];
    logic signed [31:0] w_bb  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_aa[i] = 32'(w_a[i]) * 32'(w_a[i]);
            w_bb[i] = 32'(w_b[i]) * 32'(w_b[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_s2_ab[i][j] <= 32'(w_a[i]) * 32'(w_b[j]);
                end
                r_s2_aa[i] <= w_aa[i][30:0];
                r_s2_bb[i] <= w_bb[i][30:0];
            end
        end
    end

    logic signed [32:0] r_s3_c [3];
    logic signed [33:0] r_s3_d;
    logic [31:0]        r_s3_aa;
    logic [31:0]        r_s3_bb;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_c[0] <= 33'(r_s2_ab[1][2]) - 33'(r_s2_ab[2][1]);
            r_s3_c[1] <= 33'(r_s2_ab[2][0]) - 33'(r_s2_ab[0][2]);
            r_s3_c[2] <= 33'(r_s2_ab[0][1]) - 33'(r_s2_ab[1][0]);
            r_s3_d    <= 34'(r_s2_ab[0][0]) + 34'(r_s2_ab[1][1]) + 34'(r_s2_ab[2][2]);
            r_s3_aa   <= 32'(r_s2_aa[0]) + 32'(r_s2_aa[1]) + 32'(r_s2_aa[2]);
            r_s3_bb   <= 32'(r_s2_bb[0]) + 32'(r_s2_bb[1]) + 32'(r_s2_bb[2]);
        end
    end

    logic [31:0]        w_absc [3];
    logic signed [32:0] w_negc [3];
    logic signed [33:0] w_negd;
    logic [31:0]        w_absd;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_negc[k] = -r_s3_c[k];
            w_absc[k] = r_s3_c[k][32] ? w_negc[k][31:0] : r_s3_c[k][31:0];
        end
        w_negd = -r_s3_d;
        w_absd = r_s3_d[33] ? w_negd[31:0] : r_s3_d[31:0];
    end

    logic [31:0] r_s4_absc [3];
    logic [2:0]  r_s4_cs;
    logic [31:0] r_s4_absd;
    logic        r_s4_ds;
    logic        r_s4_degen;
    logic [63:0] r_s4_ab;
    logic [63:0] r_s4_csq [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s4_absc[k] <= w_absc[k];
                r_s4_cs[k]   <= r_s3_c[k][32];
                r_s4_csq[k]  <= 64'(w_absc[k]) * 64'(w_absc[k]);
            end
            r_s4_absd  <= w_absd;
            r_s4_ds    <= r_s3_d[33];
            r_s4_degen <= (r_s3_c[0] == '0) && (r_s3_c[1] == '0) && (r_s3_c[2] == '0);
            r_s4_ab    <= 64'(r_s3_aa) * 64'(r_s3_bb);
        end
    end

    t_mid        n_s5;
    t_mid        r_s5;
    logic [63:0] r_s5_ab;

    always_comb begin
        n_s5.ss    = r_s4_csq[0] + r_s4_csq[1] + r_s4_csq[2];
        n_s5.cc[0] = 64'(r_s4_absc[0]) * 64'(r_s4_absc[1]);
        n_s5.cc[1] = 64'(r_s4_absc[0]) * 64'(r_s4_absc[2]);
        n_s5.cc[2] = 64'(r_s4_absc[1]) * 64'(r_s4_absc[2]);
        for (int k = 0; k < 3; k++) begin
            n_s5.csq[k]  = r_s4_csq[k];
            n_s5.absc[k] = r_s4_absc[k];
        end
        n_s5.csgn  = r_s4_cs;
        n_s5.absd  = r_s4_absd;
        n_s5.dsgn  = r_s4_ds;
        n_s5.degen = r_s4_degen;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5    <= n_s5;
            r_s5_ab <= r_s4_ab;
        end
    end

    t_mid        r_mid [C_SQ_ST];
    logic [31:0] w_n;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mid[0] <= r_s5;
            for (int k = 1; k < C_SQ_ST; k++) begin
                r_mid[k] <= r_mid[k-1];
            end
        end
    end

    rmtv_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r_s5_ab),
        .o_root (w_n)
    );

    t_mid             w_mt;
    logic [63:0]      w_dnum [C_NDIV];
    logic [63:0]      w_dden [C_NDIV];
    logic [C_Q_W-1:0] w_dq   [C_NDIV];

    assign w_mt = r_mid[C_SQ_ST-1];

    always_comb begin
        w_dnum[0] = 64'(w_mt.absd);
        w_dden[0] = 64'(w_n);
        for (int k = 0; k < 3; k++) begin
            w_dnum[1+k] = 64'(w_mt.absc[k]);
            w_dden[1+k] = 64'(w_n);
            w_dnum[4+k] = w_mt.csq[k];
            w_dden[4+k] = w_mt.ss;
            w_dnum[7+k] = w_mt.cc[k];
            w_dden[7+k] = w_mt.ss;
        end
    end

    for (genvar g = 0; g < C_NDIV; g++) begin : g_div
        rmtv_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (w_dnum[g]),
            .i_den  (w_dden[g]),
            .o_quot (w_dq[g])
        );
    end

    t_sgn r_sg [C_DIV_ST];
    t_sgn w_sg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sg[0] <= '{csgn: w_mt.csgn, dsgn: w_mt.dsgn, degen: w_mt.degen};
            for (int k = 1; k < C_DIV_ST; k++) begin
                r_sg[k] <= r_sg[k-1];
            end
        end
    end

    assign w_sg = r_sg[C_DIV_ST-1];

    logic signed [C_FRAC+2:0] w_cq;
    logic signed [C_FRAC+2:0] w_pq;
    logic [5:0]               w_ws;

    assign w_cq    = f_sgn(f_rnd(w_dq[0]), w_sg.dsgn);
    assign w_pq    = C_ONE_S - w_cq;
    assign w_ws[0] = 1'b0;
    assign w_ws[1] = 1'b0;
    assign w_ws[2] = 1'b0;
    assign w_ws[3] = w_sg.csgn[0] ^ w_sg.csgn[1];
    assign w_ws[4] = w_sg.csgn[0] ^ w_sg.csgn[2];
    assign w_ws[5] = w_sg.csgn[1] ^ w_sg.csgn[2];

    logic signed [C_FRAC+2:0] r_s6_cq;
    logic [C_FRAC+1:0]        r_s6_pq;
    logic signed [C_FRAC+2:0] r_s6_s  [3];
    logic [C_FRAC:0]          r_s6_wm [6];
    logic [5:0]               r_s6_ws;
    logic                     r_s6_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_cq <= w_cq;
            r_s6_pq <= w_pq[C_FRAC+1:0];
            for (int k = 0; k < 3; k++) begin
                r_s6_s[k] <= f_sgn(f_rnd(w_dq[1+k]), w_sg.csgn[k]);
            end
            for (int k = 0; k < 6; k++) begin
                r_s6_wm[k] <= f_rnd(w_dq[4+k]);
            end
            r_s6_ws    <= w_ws;
            r_s6_degen <= w_sg.degen;
        end
    end

    logic [31:0]       w_tsum [6];
    logic [C_FRAC+1:0] w_tm   [6];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_tsum[k] = 32'(r_s6_pq) * 32'(r_s6_wm[k]) + C_HALF;
            w_tm[k]   = w_tsum[k][2*C_FRAC+1:C_FRAC];
        end
    end

    logic signed [C_FRAC+2:0] r_s7_t [6];
    logic signed [C_FRAC+2:0] r_s7_cq;
    logic signed [C_FRAC+2:0] r_s7_s [3];
    logic                     r_s7_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 6; k++) begin
                r_s7_t[k] <= r_s6_ws[k] ? -$signed({1'b0, w_tm[k]}) : $signed({1'b0, w_tm[k]});
            end
            r_s7_cq    <= r_s6_cq;
            r_s7_s     <= r_s6_s;
            r_s7_degen <= r_s6_degen;
        end
    end

    logic signed [C_M_W-1:0] w_m [9];
    t_out                    n_tail;

    always_comb begin
        w_m[0] = C_M_W'(r_s7_cq) + C_M_W'(r_s7_t[0]);
        w_m[1] = C_M_W'(r_s7_t[3]) - C_M_W'(r_s7_s[2]);
        w_m[2] = C_M_W'(r_s7_t[4]) + C_M_W'(r_s7_s[1]);
        w_m[3] = C_M_W'(r_s7_t[3]) + C_M_W'(r_s7_s[2]);
        w_m[4] = C_M_W'(r_s7_cq) + C_M_W'(r_s7_t[1]);
        w_m[5] = C_M_W'(r_s7_t[5]) - C_M_W'(r_s7_s[0]);
        w_m[6] = C_M_W'(r_s7_t[4]) - C_M_W'(r_s7_s[1]);
        w_m[7] = C_M_W'(r_s7_t[5]) + C_M_W'(r_s7_s[0]);
        w_m[8] = C_M_W'(r_s7_cq) + C_M_W'(r_s7_t[2]);
        if (r_s7_degen) begin
            n_tail = '0;
            n_tail.m_row0_col0 = C_ONE_O;
            n_tail.m_row1_col1 = C_ONE_O;
            n_tail.m_row2_col2 = C_ONE_O;
            n_tail.degenerate  = 1'b1;
        end else begin
            n_tail.m_row0_col0 = f_sat(w_m[0]);
            n_tail.m_row0_col1 = f_sat(w_m[1]);
            n_tail.m_row0_col2 = f_sat(w_m[2]);
            n_tail.m_row1_col0 = f_sat(w_m[3]);
            n_tail.m_row1_col1 = f_sat(w_m[4]);
            n_tail.m_row1_col2 = f_sat(w_m[5]);
            n_tail.m_row2_col0 = f_sat(w_m[6]);
            n_tail.m_row2_col1 = f_sat(w_m[7]);
            n_tail.m_row2_col2 = f_sat(w_m[8]);
            n_tail.degenerate  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tail <= n_tail;
        end
    end

    logic w_push;
    assign w_push = r_v[C_NST-1] && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (!r_out_v || i_out_ready) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end else begin
                r_out_v <= w_push;
            end
        end else if (w_push) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_out_ready) begin
            r_out_d <= r_sk_v ? r_sk_d : r_tail;
        end else if (w_push) begin
            r_sk_d <= r_tail;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_d;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_out_v)
        else $error("Skid entry held while the output register is empty.");

    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_d.degenerate) |-> (r_out_d.m_row0_col0 == C_ONE_O
            && r_out_d.m_row1_col1 == C_ONE_O && r_out_d.m_row2_col2 == C_ONE_O
            && r_out_d.m_row0_col1 == '0 && r_out_d.m_row2_col0 == '0))
        else $error("Degenerate transaction without the identity matrix.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v))
        else $error("Pipeline valid bits moved during a stall.");

endmodule
`default_nettype wire
